// ===== hdl/nmea_gga_sentence_capture_macros.svh =====
// assertion macros shared by the gga sentence capture rtl
`ifndef NMEA_GGA_SENTENCE_CAPTURE_MACROS_SVH
`define NMEA_GGA_SENTENCE_CAPTURE_MACROS_SVH

// a condition that must hold at every clock edge out of reset
`define NGSC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// a condition that must hold in the cycle after a trigger
`define NGSC_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== hdl/ngsc_pkg.sv =====
// types, character constants and header check shared by the gga capture block
`default_nettype none

package ngsc_pkg;

   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 7;
   localparam int LEN_W     = 7;
   localparam int HEADER_LEN = 6;

   localparam logic ACT_RX   = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;
   localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;

   typedef enum logic [1:0] {
      PHASE_WAIT_DOLLAR = 2'd0,
      PHASE_HEADER      = 2'd1,
      PHASE_WAIT_CR     = 2'd2,
      PHASE_WAIT_LF     = 2'd3
   } phase_type;

   typedef struct packed {
      logic                 action;
      logic [BYTE_W-1:0]    rx_byte;
      logic [INDEX_W-1:0]   read_index;
   } item_type;

   typedef struct packed {
      logic                 done;
      logic [LEN_W-1:0]     length;
      logic                 rd_ok;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic wr_bank;
      logic rd_en;
      logic rd_bank;
   } mem_ctl_type;

   // expected character at each header position, "$G?GGA" with ? = P or N
   function automatic logic header_ok(input logic [2:0] pos, input logic [BYTE_W-1:0] b);
      logic ok;
      case (pos)
         3'd0:    ok = (b == CHAR_DOLLAR);
         3'd1:    ok = (b == CHAR_G);
         3'd2:    ok = (b == CHAR_P) || (b == CHAR_N);
         3'd3:    ok = (b == CHAR_G);
         3'd4:    ok = (b == CHAR_G);
         3'd5:    ok = (b == CHAR_A);
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ngsc_ram.sv =====
// two-bank byte store: receive bank written, capture bank read, registered read data
`default_nettype none

module ngsc_ram #(
   parameter int PW      = 7
) (
   input  wire logic                        clock,
   input  wire ngsc_pkg::mem_ctl_type       ctl,
   input  wire logic [PW-1:0]               wr_addr,
   input  wire logic [ngsc_pkg::BYTE_W-1:0] wr_data,
   input  wire logic [PW-1:0]               rd_addr,
   output logic [ngsc_pkg::BYTE_W-1:0]      rd_data
);
   import ngsc_pkg::*;

   // each bank spans the full position range so {bank, addr} stays in bounds
   logic [BYTE_W-1:0] mem_ff [2**(PW+1)];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[{ctl.wr_bank, wr_addr}] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[{ctl.rd_bank, rd_addr}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ngsc_framer.sv =====
// sentence framer: phase, write position, header check, commit by bank swap
`default_nettype none

module ngsc_framer #(
   parameter int BUF_LEN = 128,
   parameter int PW      = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire ngsc_pkg::item_type          item,
   output ngsc_pkg::result_type             result,
   output ngsc_pkg::mem_ctl_type            mem_ctl,
   output logic [PW-1:0]                    wr_addr,
   output logic [ngsc_pkg::BYTE_W-1:0]      wr_data,
   output logic [PW-1:0]                    rd_addr
);
   import ngsc_pkg::*;

   localparam int XW = PW + INDEX_W;

   phase_type     phase_ff, phase_in;
   logic [PW-1:0] write_pos_ff, write_pos_in;
   logic          header_match_ff, header_match_in;
   logic          cap_bank_ff, cap_bank_in;
   logic [PW-1:0] cap_len_ff, cap_len_in;

   logic [PW:0]   pos_inc;
   logic [XW-1:0] idx_ext;
   logic [XW-1:0] len_ext;
   logic          hm_now;
   logic          done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_WAIT_DOLLAR;
         write_pos_ff    <= '0;
         header_match_ff <= 1'b1;
         cap_bank_ff     <= 1'b0;
         cap_len_ff      <= '0;
      end else begin
         phase_ff        <= phase_in;
         write_pos_ff    <= write_pos_in;
         header_match_ff <= header_match_in;
         cap_bank_ff     <= cap_bank_in;
         cap_len_ff      <= cap_len_in;
      end
   end

   always_comb begin
      pos_inc         = {1'b0, write_pos_ff} + (PW+1)'(1);
      idx_ext         = XW'(item.read_index);
      hm_now          = header_match_ff & header_ok(write_pos_ff[2:0], item.rx_byte);
      phase_in        = phase_ff;
      write_pos_in    = write_pos_ff;
      header_match_in = header_match_ff;
      cap_bank_in     = cap_bank_ff;
      cap_len_in      = cap_len_ff;
      done            = 1'b0;

      if (step && (item.action == ACT_RX)) begin
         if (pos_inc >= (PW+1)'(BUF_LEN)) begin
            // buffer full: drop the run and start over
            phase_in     = PHASE_WAIT_DOLLAR;
            write_pos_in = '0;
         end else begin
            write_pos_in = pos_inc[PW-1:0];
            case (phase_ff)
               PHASE_WAIT_DOLLAR: begin
                  if (item.rx_byte == CHAR_DOLLAR) begin
                     phase_in        = PHASE_HEADER;
                     header_match_in = 1'b1;
                  end else begin
                     write_pos_in = '0;
                  end
               end
               PHASE_HEADER: begin
                  header_match_in = hm_now;
                  if (pos_inc == (PW+1)'(HEADER_LEN)) begin
                     if (hm_now) begin
                        phase_in = PHASE_WAIT_CR;
                     end else begin
                        phase_in     = PHASE_WAIT_DOLLAR;
                        write_pos_in = '0;
                     end
                  end
               end
               PHASE_WAIT_CR: begin
                  if (item.rx_byte == CHAR_CR) begin
                     phase_in = PHASE_WAIT_LF;
                  end
               end
               PHASE_WAIT_LF: begin
                  if (item.rx_byte == CHAR_LF) begin
                     // receive bank becomes the capture bank
                     cap_bank_in  = ~cap_bank_ff;
                     cap_len_in   = pos_inc[PW-1:0];
                     phase_in     = PHASE_WAIT_DOLLAR;
                     write_pos_in = '0;
                     done         = 1'b1;
                  end
               end
               default: begin
                  phase_in = PHASE_WAIT_DOLLAR;
               end
            endcase
         end
      end

      len_ext = XW'(cap_len_in);

      result.done   = done;
      result.length = len_ext[LEN_W-1:0];
      result.rd_ok  = step && (item.action == ACT_READ)
                      && (idx_ext < XW'(cap_len_ff)) && (idx_ext < XW'(BUF_LEN));

      mem_ctl.wr_en   = step && (item.action == ACT_RX);
      mem_ctl.wr_bank = ~cap_bank_ff;
      mem_ctl.rd_en   = step && (item.action == ACT_READ);
      mem_ctl.rd_bank = cap_bank_ff;

      wr_addr = write_pos_ff;
      wr_data = item.rx_byte;
      rd_addr = idx_ext[PW-1:0];
   end

endmodule

`default_nettype wire

// ===== hdl/nmea_gga_sentence_capture.sv =====
// top level of the gga sentence capture block: input register, framer, store, result register
//
//   channel  dir  tdata (low bit up)                           side band
//   req_     in   rx_byte[7:0], read_index[14:8], pad[15]      tuser = action
//   rsp_     out  sentence_length[6:0], read_byte[14:7], pad   tlast = sentence_done
//
// one word accepted per cycle, sustained while rsp_ is not stalled; a result is offered in the
//   cycle after its word moves on from the input register into the result register
// the rate is set by the single framer update and one store access per word
// a stalled rsp_ side holds the result register; req_ keeps taking a word while the
//   input register can move on, so at most two words are held inside
// synchronous active-high reset clears phase, position, length and both valid flags;
//   the byte store is not cleared and is only read below the committed length
`default_nettype none
`include "nmea_gga_sentence_capture_macros.svh"

module nmea_gga_sentence_capture #(
   parameter int BUF_LEN = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], read_index[14:8], zero[15]
   input  wire logic        req_tuser,   // action
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // sentence_length[6:0], read_byte[14:7], zero[15]
   output logic             rsp_tlast    // sentence_done
);
   import ngsc_pkg::*;

   localparam int PW = $clog2(BUF_LEN);

   // input register
   logic       a_valid_ff, a_valid_in;
   item_type   a_item_ff;

   // result register (read byte is held inside the store)
   logic       b_valid_ff, b_valid_in;
   result_type b_res_ff;

   logic        advance;
   result_type  res;
   mem_ctl_type mem_ctl;
   logic [PW-1:0]     wr_addr;
   logic [PW-1:0]     rd_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] read_byte;

   // the word in the input register moves on when the result register is free or drains
   assign advance    = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance;
   assign a_valid_in = (req_tvalid && req_tready) || (a_valid_ff && !advance);
   assign b_valid_in = advance || (b_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_item_ff.action     <= req_tuser;
         a_item_ff.rx_byte    <= req_tdata[7:0];
         a_item_ff.read_index <= req_tdata[14:8];
      end
      if (advance) begin
         b_res_ff <= res;
      end
   end

   ngsc_framer #(
      .BUF_LEN (BUF_LEN),
      .PW      (PW)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (a_item_ff),
      .result  (res),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr)
   );

   ngsc_ram #(
      .PW      (PW)
   ) u_ram (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // bytes at or past the committed length read as zero, as do received-byte words
   assign read_byte  = b_res_ff.rd_ok ? rd_data : '0;
   assign rsp_tvalid = b_valid_ff;
   assign rsp_tlast  = b_res_ff.done;
   assign rsp_tdata  = {1'b0, read_byte, b_res_ff.length};

   // a commit only comes from a received byte, never from a read
   `NGSC_ASSERT_ALWAYS(a_done_no_read, !(rsp_tvalid && rsp_tlast && (read_byte != '0)), "done data")
   // both registers full and the output stalled: no room for another word
   `NGSC_ASSERT_ALWAYS(a_no_overrun, !(a_valid_ff && b_valid_ff && !rsp_tready && req_tready), "overrun")
   // a word moved on is offered on the result side next cycle
   `NGSC_ASSERT_NEXT(a_advance_shows, advance, rsp_tvalid, "advanced word not presented")

endmodule

`default_nettype wire
